/* sv/bb3_pkg.sv */
// Shared types, constants and arithmetic helpers of the 3x3 RGB box blur.
// Used by the line buffer, the top level and the testbench; no dependencies.
package bb3_pkg;

    localparam int MAX_LINE  = 1024;
    localparam int MAX_LINES = 4096;

    localparam int COL_W = $clog2(MAX_LINE);
    localparam int ROW_W = $clog2(MAX_LINES);
    localparam int LEN_W = 11;
    localparam int CNT_W = 13;

    localparam logic [LEN_W-1:0] LEN_RESET = 11'd600;
    localparam logic [CNT_W-1:0] CNT_RESET = 13'd800;
    localparam logic [LEN_W-1:0] LEN_MIN   = 11'd3;
    localparam logic [LEN_W-1:0] LEN_MAX   = 11'd1024;
    localparam logic [CNT_W-1:0] CNT_MIN   = 13'd3;
    localparam logic [CNT_W-1:0] CNT_MAX   = 13'd4096;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] REG_LINE_LENGTH = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_COUNT  = 8'd1;

    localparam int CHAN_W = 8;
    localparam int CSUM_W = 10;
    localparam int SUM_W  = 12;
    localparam int AVG_W  = 12;

    // ceil(2^21 / 9); exact floor division by nine for every operand below 2^17.
    localparam int              RECIP_SHIFT = 21;
    localparam logic [17:0]     RECIP       = 18'd233017;

    typedef struct packed {
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } pix_t;

    typedef struct packed {
        logic [CSUM_W-1:0] blue;
        logic [CSUM_W-1:0] green;
        logic [CSUM_W-1:0] red;
    } csum_t;

    typedef struct packed {
        logic [SUM_W-1:0] blue;
        logic [SUM_W-1:0] green;
        logic [SUM_W-1:0] red;
    } wsum_t;

    typedef struct packed {
        logic             rd_en;
        logic [COL_W-1:0] rd_addr;
        logic             wr_en;
        logic [COL_W-1:0] wr_addr;
    } lb_req_t;

    // Sum of one column of three pixels, channel by channel.
    function automatic csum_t col_sum(input pix_t a, input pix_t b, input pix_t c);
        csum_t s;
        s.red   = CSUM_W'(a.red)   + CSUM_W'(b.red)   + CSUM_W'(c.red);
        s.green = CSUM_W'(a.green) + CSUM_W'(b.green) + CSUM_W'(c.green);
        s.blue  = CSUM_W'(a.blue)  + CSUM_W'(b.blue)  + CSUM_W'(c.blue);
        return s;
    endfunction

    // Mean of nine values in unsigned 8.4, rounded: (16*s + 4) / 9.
    function automatic logic [AVG_W-1:0] mean_8p4(input logic [SUM_W-1:0] s);
        logic [15:0] x;
        logic [33:0] p;
        x = {s, 4'd0} + 16'd4;
        p = {18'd0, x} * {16'd0, RECIP};
        return p[RECIP_SHIFT +: AVG_W];
    endfunction

endpackage

/* sv/bb3_line_buf.sv */
// Two line stores of the box blur, one pixel per entry, registered read.
// Depends on bb3_pkg for the pixel type and the access request struct.
module bb3_line_buf (
    input  logic            aclk,
    input  bb3_pkg::lb_req_t req,
    input  bb3_pkg::pix_t   wr_b,    // value for the older line store
    input  bb3_pkg::pix_t   wr_a,    // value for the newer line store
    output bb3_pkg::pix_t   top_q,   // older line store read data
    output bb3_pkg::pix_t   mid_q    // newer line store read data
);

    bb3_pkg::pix_t store_b_mem [bb3_pkg::MAX_LINE];
    bb3_pkg::pix_t store_a_mem [bb3_pkg::MAX_LINE];
    bb3_pkg::pix_t top_q_reg;
    bb3_pkg::pix_t mid_q_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            store_b_mem[req.wr_addr] <= wr_b;
            store_a_mem[req.wr_addr] <= wr_a;
        end
        if (req.rd_en) begin
            top_q_reg <= store_b_mem[req.rd_addr];
            mid_q_reg <= store_a_mem[req.rd_addr];
        end
    end

    assign top_q = top_q_reg;
    assign mid_q = mid_q_reg;

endmodule

/* sv/box_blur_3x3_rgb_top.sv */
// Top level of the 3x3 RGB box blur: raster counters, window of column sums,
// three-stage pipeline and configuration registers. Uses bb3_pkg and bb3_line_buf.
// Throughput: one pixel per clock while m_tready does not stall the output register;
// the line store read and write each take one port a cycle. The pixel completing a window
// is registered with the line store read, then as window sum, then divided by nine.
// Reset: aresetn is synchronous, active low; it empties the pipeline, zeroes the
// counters and window, and loads line_length 600 and line_count 800. No clearing pass.
module box_blur_3x3_rgb_top (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [23:0]                      s_tdata,   // red_in, green_in, blue_in
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // red_avg, green_avg, blue_avg, center_row, center_col, zero padding
    output logic [63:0]                      m_tdata,
    output logic                             m_tlast,   // frame_last
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bb3_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bb3_pkg::CFG_DATA_W-1:0]   cfg_data
);

    // Configuration and raster position
    logic [bb3_pkg::LEN_W-1:0] line_length_reg;
    logic [bb3_pkg::CNT_W-1:0] line_count_reg;
    logic [bb3_pkg::LEN_W-1:0] len_eff;
    logic [bb3_pkg::CNT_W-1:0] cnt_eff;
    logic [bb3_pkg::ROW_W-1:0] row_reg, row_next;
    logic [bb3_pkg::COL_W-1:0] col_reg, col_next;
    logic                      col_end, row_end, cfg_hit;

    // Stage A: pixel and line store read data
    logic                      a_valid_reg;
    bb3_pkg::pix_t             a_px_reg;
    logic [bb3_pkg::ROW_W-1:0] a_row_reg;
    logic [bb3_pkg::COL_W-1:0] a_col_reg;
    logic                      a_prod_reg;
    logic                      a_last_reg;

    // Stage S: window sums
    logic                      s_valid_reg;
    bb3_pkg::wsum_t            s_sum_reg;
    logic [bb3_pkg::ROW_W-1:0] s_row_reg;
    logic [bb3_pkg::COL_W-1:0] s_col_reg;
    logic                      s_last_reg;

    // Output register
    logic                      m_valid_reg;
    logic [bb3_pkg::AVG_W-1:0] m_red_reg, m_green_reg, m_blue_reg;
    logic [bb3_pkg::ROW_W-1:0] m_row_reg;
    logic [bb3_pkg::COL_W-1:0] m_col_reg;
    logic                      m_last_reg;

    // Window of the two previous column sums
    bb3_pkg::csum_t            win0_reg, win1_reg;

    bb3_pkg::lb_req_t          lb_req;
    bb3_pkg::pix_t             top_px, mid_px, px_in;
    bb3_pkg::csum_t            cur_cs;
    bb3_pkg::wsum_t            win_sum;
    logic                      in_xfer, a_adv, s_adv, s_free;

    assign px_in = bb3_pkg::pix_t'(s_tdata);

    always_comb begin
        if (line_length_reg < bb3_pkg::LEN_MIN) begin
            len_eff = bb3_pkg::LEN_MIN;
        end else if (line_length_reg > bb3_pkg::LEN_MAX) begin
            len_eff = bb3_pkg::LEN_MAX;
        end else begin
            len_eff = line_length_reg;
        end
        if (line_count_reg < bb3_pkg::CNT_MIN) begin
            cnt_eff = bb3_pkg::CNT_MIN;
        end else if (line_count_reg > bb3_pkg::CNT_MAX) begin
            cnt_eff = bb3_pkg::CNT_MAX;
        end else begin
            cnt_eff = line_count_reg;
        end
    end

    assign col_end = ({1'b0, col_reg} == (len_eff - 11'd1));
    assign row_end = ({1'b0, row_reg} == (cnt_eff - 13'd1));

    always_comb begin
        row_next = row_reg;
        col_next = col_reg + 1'b1;
        if (col_end) begin
            col_next = '0;
            row_next = row_end ? '0 : row_reg + 1'b1;
        end
    end

    // Handshake chain: a pixel with no result leaves stage A without waiting.
    assign s_adv    = s_valid_reg && (!m_valid_reg || m_tready);
    assign s_free   = !s_valid_reg || s_adv;
    assign a_adv    = a_valid_reg && (!a_prod_reg || s_free);
    assign s_tready = !a_valid_reg || a_adv;
    assign in_xfer  = s_tvalid && s_tready;

    assign cfg_ready = 1'b1;
    assign cfg_hit   = cfg_valid && (cfg_index == bb3_pkg::REG_LINE_LENGTH ||
                                     cfg_index == bb3_pkg::REG_LINE_COUNT);

    // The pixel read out of the newer store moves to the older one.
    assign lb_req.rd_en   = in_xfer;
    assign lb_req.rd_addr = col_reg;
    assign lb_req.wr_en   = a_adv;
    assign lb_req.wr_addr = a_col_reg;

    bb3_line_buf u_line_buf (
        .aclk  (aclk),
        .req   (lb_req),
        .wr_b  (mid_px),
        .wr_a  (a_px_reg),
        .top_q (top_px),
        .mid_q (mid_px)
    );

    assign cur_cs = bb3_pkg::col_sum(top_px, mid_px, a_px_reg);

    always_comb begin
        win_sum.red   = bb3_pkg::SUM_W'(cur_cs.red) + bb3_pkg::SUM_W'(win0_reg.red)
                      + bb3_pkg::SUM_W'(win1_reg.red);
        win_sum.green = bb3_pkg::SUM_W'(cur_cs.green) + bb3_pkg::SUM_W'(win0_reg.green)
                      + bb3_pkg::SUM_W'(win1_reg.green);
        win_sum.blue  = bb3_pkg::SUM_W'(cur_cs.blue) + bb3_pkg::SUM_W'(win0_reg.blue)
                      + bb3_pkg::SUM_W'(win1_reg.blue);
    end

    // Configuration, counters and window
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_length_reg <= bb3_pkg::LEN_RESET;
            line_count_reg  <= bb3_pkg::CNT_RESET;
            row_reg         <= '0;
            col_reg         <= '0;
            win0_reg        <= '0;
            win1_reg        <= '0;
        end else if (cfg_hit) begin
            if (cfg_index == bb3_pkg::REG_LINE_LENGTH) begin
                line_length_reg <= cfg_data[bb3_pkg::LEN_W-1:0];
            end else begin
                line_count_reg  <= cfg_data;
            end
            row_reg  <= '0;
            col_reg  <= '0;
            win0_reg <= '0;
            win1_reg <= '0;
        end else begin
            if (in_xfer) begin
                row_reg <= row_next;
                col_reg <= col_next;
            end
            if (a_adv) begin
                win1_reg <= win0_reg;
                win0_reg <= cur_cs;
            end
        end
    end

    // Pipeline valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            s_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (in_xfer) begin
                a_valid_reg <= 1'b1;
            end else if (a_adv) begin
                a_valid_reg <= 1'b0;
            end
            if (a_adv && a_prod_reg) begin
                s_valid_reg <= 1'b1;
            end else if (s_adv) begin
                s_valid_reg <= 1'b0;
            end
            if (s_adv) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Pipeline payload
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            a_px_reg   <= px_in;
            a_row_reg  <= row_reg;
            a_col_reg  <= col_reg;
            a_prod_reg <= (row_reg >= 12'd2) && (col_reg >= 10'd2);
            a_last_reg <= row_end && col_end;
        end
        if (a_adv && a_prod_reg) begin
            s_sum_reg  <= win_sum;
            s_row_reg  <= a_row_reg - 1'b1;
            s_col_reg  <= a_col_reg - 1'b1;
            s_last_reg <= a_last_reg;
        end
        if (s_adv) begin
            m_red_reg   <= bb3_pkg::mean_8p4(s_sum_reg.red);
            m_green_reg <= bb3_pkg::mean_8p4(s_sum_reg.green);
            m_blue_reg  <= bb3_pkg::mean_8p4(s_sum_reg.blue);
            m_row_reg   <= s_row_reg;
            m_col_reg   <= s_col_reg;
            m_last_reg  <= s_last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {6'd0, m_col_reg, m_row_reg, m_blue_reg, m_green_reg, m_red_reg};

endmodule

/* sv/bb3_checker.sv */
// Port-level checker for the 3x3 RGB box blur, attached to the top level by bind.
// Sees only the top-level ports; depends on nothing else.
module bb3_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic        m_tlast,
    input logic        cfg_ready
);

    // A result waiting for the sink keeps its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // Means never exceed 255.0 in 8.4 form.
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[11:0] <= 12'd4080 && m_tdata[23:12] <= 12'd4080 &&
                     m_tdata[35:24] <= 12'd4080)
        else $error("mean out of range");

    // Only interior centres are reported, and the padding stays clear.
    a_interior: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[47:36] != 12'd0 && m_tdata[57:48] != 10'd0 &&
                     m_tdata[63:58] == 6'd0)
        else $error("border centre or bad padding");

    // Reset empties the output register.
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // Configuration writes are always taken.
    a_cfg: assert property (@(posedge aclk) disable iff (!aresetn) cfg_ready)
        else $error("configuration port stalled");

endmodule

bind box_blur_3x3_rgb_top bb3_checker u_bb3_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_ready (cfg_ready)
);

/* verif/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking bench for box_blur_3x3_rgb_top: drives pixel streams and geometry writes,
// predicts each 3x3 mean and compares every result transfer. Needs bb3_pkg and the RTL only.
module tb_top;

    localparam int  CYCLE_LIMIT  = 1000000;
    localparam int  SETTLE       = 8;
    localparam int  RANDOM_ITEMS = 600;

    typedef struct packed {
        logic [bb3_pkg::AVG_W-1:0] r_avg;
        logic [bb3_pkg::AVG_W-1:0] g_avg;
        logic [bb3_pkg::AVG_W-1:0] b_avg;
        logic [bb3_pkg::ROW_W-1:0] row;
        logic [bb3_pkg::COL_W-1:0] col;
        logic                      last;
    } blur_out_t;

    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [23:0]                    s_tdata   = '0;
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [63:0]                    m_tdata;
    logic                           m_tlast;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [bb3_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [bb3_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    // Shadow copy of the filter state.
    bb3_pkg::pix_t             line_prev  [bb3_pkg::MAX_LINE];
    bb3_pkg::pix_t             line_older [bb3_pkg::MAX_LINE];
    bb3_pkg::pix_t             win_q      [6];
    logic [bb3_pkg::ROW_W-1:0] at_row = '0;
    logic [bb3_pkg::COL_W-1:0] at_col = '0;
    logic [bb3_pkg::LEN_W-1:0] geo_len = bb3_pkg::LEN_RESET;
    logic [bb3_pkg::CNT_W-1:0] geo_cnt = bb3_pkg::CNT_RESET;

    blur_out_t   pending_means[$];
    int unsigned err_count = 0;
    int unsigned cycle_cnt = 0;
    int          hold_left = 0;
    logic [15:0] rx_tick   = '0;
    bit          gaps_on   = 1'b1;
    int          burst_left = 0;

    box_blur_3x3_rgb_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic int unsigned fit_range(input int unsigned v, input int unsigned hi);
        if (v < 3) begin
            return 3;
        end
        return (v > hi) ? hi : v;
    endfunction

    function automatic logic [bb3_pkg::AVG_W-1:0] ninth_8p4(input int unsigned s);
        return bb3_pkg::AVG_W'((s * 16 + 4) / 9);
    endfunction

    function automatic bb3_pkg::pix_t rand_pixel();
        bb3_pkg::pix_t p;
        case ($urandom_range(0, 15))
            0:       p = '0;
            1:       p = '1;
            default: p = bb3_pkg::pix_t'(24'($urandom));
        endcase
        return p;
    endfunction

    task automatic restart_frame();
        at_row = '0;
        at_col = '0;
        for (int k = 0; k < 6; k++) win_q[k] = '0;
    endtask

    // Advances the shadow filter by one pixel and queues the mean it completes, if any.
    task automatic blur_window_step(input bb3_pkg::pix_t px);
        int unsigned   len_eff, cnt_eff, nxt_col, nxt_row;
        int unsigned   sum_r, sum_g, sum_b;
        bb3_pkg::pix_t top, mid;
        bb3_pkg::pix_t nine[9];
        blur_out_t     res;
        len_eff = fit_range(geo_len, bb3_pkg::MAX_LINE);
        cnt_eff = fit_range(geo_cnt, bb3_pkg::MAX_LINES);
        top = line_older[at_col];
        mid = line_prev[at_col];
        line_older[at_col] = mid;
        line_prev[at_col]  = px;
        if (at_row >= 2 && at_col >= 2) begin
            nine[0] = top;
            nine[1] = mid;
            nine[2] = px;
            for (int k = 0; k < 6; k++) nine[3 + k] = win_q[k];
            sum_r = 0;
            sum_g = 0;
            sum_b = 0;
            for (int k = 0; k < 9; k++) begin
                sum_r += nine[k].red;
                sum_g += nine[k].green;
                sum_b += nine[k].blue;
            end
            res.r_avg = ninth_8p4(sum_r);
            res.g_avg = ninth_8p4(sum_g);
            res.b_avg = ninth_8p4(sum_b);
            res.row   = at_row - 1'b1;
            res.col   = at_col - 1'b1;
            res.last  = (at_row == cnt_eff - 1) && (at_col == len_eff - 1);
            pending_means.push_back(res);
        end
        win_q[3] = win_q[0];
        win_q[4] = win_q[1];
        win_q[5] = win_q[2];
        win_q[0] = top;
        win_q[1] = mid;
        win_q[2] = px;
        nxt_col = at_col + 1;
        nxt_row = at_row;
        if (nxt_col >= len_eff) begin
            nxt_col = 0;
            nxt_row = at_row + 1;
            if (nxt_row >= cnt_eff) begin
                nxt_row = 0;
            end
        end
        at_col = bb3_pkg::COL_W'(nxt_col);
        at_row = bb3_pkg::ROW_W'(nxt_row);
    endtask

    // Offers one pixel, with bursts and gaps, and returns once it has been transferred.
    // The valid stays high so that back-to-back pixels never toggle it within one step.
    task automatic push_pixel(input bb3_pkg::pix_t px);
        if (gaps_on && burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = $urandom_range(1, 24);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        do @(posedge aclk); while (!s_tready);
        blur_window_step(px);
        if (burst_left > 0) begin
            burst_left--;
        end
    endtask

    task automatic push_random(input int n);
        for (int i = 0; i < n; i++) push_pixel(rand_pixel());
    endtask

    task automatic pixels_stop();
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_results_drained();
        @(posedge aclk);
        while (pending_means.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [bb3_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bb3_pkg::CFG_DATA_W-1:0] val);
        pixels_stop();
        wait_results_drained();
        // Pixels that complete no window may still be in the pipeline.
        repeat (SETTLE) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            bb3_pkg::REG_LINE_LENGTH: begin
                geo_len = val[bb3_pkg::LEN_W-1:0];
                restart_frame();
            end
            bb3_pkg::REG_LINE_COUNT: begin
                geo_cnt = val[bb3_pkg::CNT_W-1:0];
                restart_frame();
            end
            default: ;
        endcase
    endtask

    task automatic cmp_field(input string what, input int unsigned want,
                             input int unsigned got);
        if (want != got) begin
            $display("%t: %s expected %0d, got %0d", $time, what, want, got);
            err_count++;
        end
    endtask

    always @(posedge aclk) begin
        blur_out_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.r_avg = m_tdata[11:0];
            got.g_avg = m_tdata[23:12];
            got.b_avg = m_tdata[35:24];
            got.row   = m_tdata[47:36];
            got.col   = m_tdata[57:48];
            got.last  = m_tlast;
            if (pending_means.size() == 0) begin
                $display("%t: unexpected result transfer, expected none, got %h last %b",
                         $time, m_tdata, m_tlast);
                err_count++;
            end else begin
                want = pending_means.pop_front();
                cmp_field("red_avg",    want.r_avg, got.r_avg);
                cmp_field("green_avg",  want.g_avg, got.g_avg);
                cmp_field("blue_avg",   want.b_avg, got.b_avg);
                cmp_field("center_row", want.row,   got.row);
                cmp_field("center_col", want.col,   got.col);
                cmp_field("frame_last", want.last,  got.last);
            end
        end
    end

    // Receiver: a long hold when one is requested, otherwise a pattern of phases set by rx_tick[8:7].
    always @(posedge aclk) begin
        rx_tick <= rx_tick + 1'b1;
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            case (rx_tick[8:7])
                2'd0:    m_tready <= 1'b1;
                2'd1:    m_tready <= ($urandom_range(0, 3) != 0);
                2'd2:    m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= (rx_tick[2:0] < 3'd5);
            endcase
        end
    end

    // Default line length of 600: a short run after reset completes no window yet.
    task automatic test_reset_geometry();
        push_random(40);
    endtask

    // Below-range writes give the 3 by 3 frame: one mean per frame, always the last.
    task automatic test_smallest_frame();
        bb3_pkg::pix_t check_px;
        write_reg(bb3_pkg::REG_LINE_LENGTH, 13'd0);
        write_reg(bb3_pkg::REG_LINE_COUNT, 13'd2);
        for (int i = 0; i < 9; i++) push_pixel('1);
        for (int i = 0; i < 9; i++) push_pixel('0);
        for (int i = 0; i < 4; i++) begin
            check_px = (i % 2) ? bb3_pkg::pix_t'(24'hFF00FF) : bb3_pkg::pix_t'(24'h00FF00);
            push_pixel(check_px);
        end
        // Writes to unknown indexes must leave the frame position alone.
        write_reg(bb3_pkg::CFG_IDX_W'(2), 13'h1FFF);
        write_reg('1, 13'd0);
        push_random(5);
    endtask

    // All data bits set: the length field keeps 2047, which saturates to the longest line,
    // so a short run in a three-line frame completes no window.
    task automatic test_longest_line();
        write_reg(bb3_pkg::REG_LINE_LENGTH, 13'h1FFF);
        write_reg(bb3_pkg::REG_LINE_COUNT, 13'd3);
        push_random(48);
    endtask

    // An over-range count saturates to the most lines, so rows run on past any small count.
    task automatic test_most_lines();
        write_reg(bb3_pkg::REG_LINE_LENGTH, 13'd3);
        write_reg(bb3_pkg::REG_LINE_COUNT, 13'h1FFF);
        push_random(3 * 12 + 3);
        write_reg(bb3_pkg::REG_LINE_COUNT, 13'd4096);
        push_random(12);
    endtask

    // A long receiver hold fills the pipeline and must stall the input side.
    task automatic test_output_stall();
        write_reg(bb3_pkg::REG_LINE_LENGTH, 13'd8);
        write_reg(bb3_pkg::REG_LINE_COUNT, 13'd6);
        gaps_on = 1'b0;
        hold_left = 400;
        push_random(120);
        pixels_stop();
        wait_results_drained();
        gaps_on = 1'b1;
        push_random(40);
    endtask

    task automatic test_random_frames();
        int          sent, n, n_lo, n_hi, sel;
        int unsigned len, cnt;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            sel = $urandom_range(0, 31);
            if (sel == 0) begin
                len = $urandom_range(0, 2);
                cnt = $urandom_range(0, 2);
            end else if (sel == 1) begin
                len = $urandom_range(1025, 2047);
                cnt = $urandom_range(4097, 8191);
            end else if (sel < 6) begin
                len = $urandom_range(13, 80);
                cnt = $urandom_range(3, 8);
            end else begin
                len = $urandom_range(3, 12);
                cnt = $urandom_range(3, 8);
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: begin
                    write_reg(bb3_pkg::REG_LINE_LENGTH, {2'($urandom), 11'(len)});
                    write_reg(bb3_pkg::REG_LINE_COUNT, 13'(cnt));
                end
                6:       write_reg(bb3_pkg::REG_LINE_COUNT, 13'(cnt));
                7:       write_reg(bb3_pkg::REG_LINE_LENGTH, {2'($urandom), 11'(len)});
                8:       write_reg(bb3_pkg::CFG_IDX_W'($urandom_range(2, 255)),
                                   13'($urandom));
                default: ;
            endcase
            gaps_on = ($urandom_range(0, 3) != 0);
            n_hi = 2 * fit_range(geo_len, bb3_pkg::MAX_LINE)
                     * fit_range(geo_cnt, bb3_pkg::MAX_LINES) + 3;
            if (n_hi > 200) begin
                n_hi = 200;
            end
            n_lo = n_hi / 4 + 1;
            n = $urandom_range(n_lo, n_hi);
            push_random(n);
            sent += n;
        end
        gaps_on = 1'b1;
    endtask

    initial begin
        for (int i = 0; i < bb3_pkg::MAX_LINE; i++) begin
            line_prev[i]  = '0;
            line_older[i] = '0;
        end
        restart_frame();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_geometry();
        test_smallest_frame();
        test_longest_line();
        test_most_lines();
        test_output_stall();
        test_random_frames();
        pixels_stop();
        wait_results_drained();
        repeat (2 * SETTLE) @(posedge aclk);
        if (err_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
